[design/utf8_byte_sanitizer_defines.svh]
// Assertion macros shared by the sanitizer RTL.
`ifndef UTF8_BYTE_SANITIZER_DEFINES_SVH
`define UTF8_BYTE_SANITIZER_DEFINES_SVH

// Same-cycle implication.
`define UTF8S_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define UTF8S_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/utf8s_pkg.sv]
// Types and constants for the UTF-8 byte sanitizer.
package utf8s_pkg;

   localparam logic [7:0] QMARK      = 8'h3F;
   localparam int         MAX_BURST  = 4;
   localparam int         FIFO_DEPTH = 8;
   localparam int         PTR_W      = $clog2(FIFO_DEPTH);
   localparam int         CNT_W      = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic [2:0]      count;
      logic [3:0][7:0] data;
   } burst_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       string_last;
   } entry_type;

endpackage

[design/utf8s_ifs.sv]
// Valid/ready channel interfaces for the sanitizer input and result streams.
interface utf8s_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       string_end;

   modport source (output valid, output in_byte, output string_end, input ready);
   modport sink   (input valid, input in_byte, input string_end, output ready);
endinterface

interface utf8s_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       string_last;

   modport source (output valid, output out_byte, output run_last, output string_last,
                   input ready);
   modport sink   (input valid, input out_byte, input run_last, input string_last,
                   output ready);
endinterface

[design/utf8s_decode.sv]
// Sequence tracker: holds a pending multi-byte run and forms the output burst per byte.
`include "utf8_byte_sanitizer_defines.svh"

module utf8s_decode (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           in_byte,
   input  logic                 string_end,
   output utf8s_pkg::burst_type burst
);
   import utf8s_pkg::*;

   logic [7:0] pend_ff [3];
   logic [1:0] pend_cnt_ff;
   logic [1:0] pend_cnt_in;
   logic [2:0] seq_len_ff;
   logic [2:0] seq_len_in;

   logic       is_cont;
   logic       is_ascii;
   logic [2:0] lead_len;
   logic       fresh_hold;
   logic       have;
   logic       complete;
   logic       extend;
   logic       tail_valid;
   logic [7:0] tail_byte;

   assign is_cont  = (in_byte[7:6] == 2'b10);
   assign is_ascii = !in_byte[7];

   always_comb begin
      if (in_byte[7:5] == 3'b110) begin
         lead_len = 3'd2;
      end else if (in_byte[7:4] == 4'b1110) begin
         lead_len = 3'd3;
      end else if (in_byte[7:3] == 5'b11110) begin
         lead_len = 3'd4;
      end else begin
         lead_len = 3'd0;
      end
   end

   assign fresh_hold = (lead_len != 3'd0) && !string_end;
   assign have       = (pend_cnt_ff != 2'd0);
   assign complete   = have && is_cont && (({1'b0, pend_cnt_ff} + 3'd1) >= seq_len_ff);
   assign extend     = have && is_cont && !complete;

   // extend with string end replaces the held run plus this byte with question marks
   assign tail_valid = complete || (extend && string_end) ||
                       (!extend && !complete && !fresh_hold);

   always_comb begin
      if (complete) begin
         tail_byte = in_byte;
      end else if (extend) begin
         tail_byte = QMARK;
      end else if (is_ascii) begin
         tail_byte = in_byte;
      end else begin
         tail_byte = QMARK;
      end
   end

   always_comb begin
      // a byte that only extends the held run releases nothing
      burst.count = (extend && !string_end) ? 3'd0 :
                    ({1'b0, pend_cnt_ff} + {2'b00, tail_valid});
      for (int i = 0; i < 3; i++) begin
         if (2'(i) < pend_cnt_ff) begin
            burst.data[i] = complete ? pend_ff[i] : QMARK;
         end else begin
            burst.data[i] = tail_byte;
         end
      end
      burst.data[3] = tail_byte;
   end

   always_comb begin
      pend_cnt_in = pend_cnt_ff;
      seq_len_in  = seq_len_ff;
      if (accept) begin
         if (complete) begin
            pend_cnt_in = 2'd0;
            seq_len_in  = 3'd0;
         end else if (extend) begin
            if (string_end) begin
               pend_cnt_in = 2'd0;
               seq_len_in  = 3'd0;
            end else begin
               pend_cnt_in = pend_cnt_ff + 2'd1;
            end
         end else if (fresh_hold) begin
            pend_cnt_in = 2'd1;
            seq_len_in  = lead_len;
         end else begin
            pend_cnt_in = 2'd0;
            seq_len_in  = 3'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_cnt_ff <= 2'd0;
         seq_len_ff  <= 3'd0;
      end else begin
         pend_cnt_ff <= pend_cnt_in;
         seq_len_ff  <= seq_len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (extend) begin
            pend_ff[pend_cnt_ff] <= in_byte;
         end else if (!complete && fresh_hold) begin
            pend_ff[0] <= in_byte;
         end
      end
   end

   `UTF8S_ASSERT_IMP(a_len_covers_cnt, clock, reset, pend_cnt_ff != 2'd0, seq_len_ff > {1'b0, pend_cnt_ff}, "held run longer than its form")
   `UTF8S_ASSERT_NXT(a_silent_holds, clock, reset, accept && (burst.count == 3'd0), pend_cnt_ff != 2'd0, "silent byte left nothing held")

endmodule

[design/utf8_byte_sanitizer.sv]
// Top level of the UTF-8 byte sanitizer: sequence tracker and result queue.
// Results are registered in the queue when their input byte transfers and offered on rsp_chan from its head.
// Throughput: one input byte per cycle while ready, one result byte per cycle while
// rsp_chan is ready; a byte may release up to four results into an 8-entry queue.
// Input is taken while the queue has room for four results.
// Reset (synchronous) drops any held run and empties the queue.
`include "utf8_byte_sanitizer_defines.svh"

module utf8_byte_sanitizer (
   input logic         clock,
   input logic         reset,
   utf8s_req_if.sink   req_chan,
   utf8s_rsp_if.source rsp_chan
);
   import utf8s_pkg::*;

   entry_type        fifo_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] push_cnt;
   logic [CNT_W-1:0] pop_cnt;
   logic             accept;
   logic             pop;
   burst_type        burst;

   assign req_chan.ready = (count_ff <= CNT_W'(FIFO_DEPTH - MAX_BURST));
   assign accept         = req_chan.valid && req_chan.ready;
   assign pop            = rsp_chan.valid && rsp_chan.ready;

   utf8s_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .in_byte    (req_chan.in_byte),
      .string_end (req_chan.string_end),
      .burst      (burst)
   );

   assign push_cnt  = accept ? CNT_W'(burst.count) : '0;
   assign pop_cnt   = CNT_W'(pop);
   assign count_in  = count_ff + push_cnt - pop_cnt;
   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push_cnt);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_BURST; i++) begin
         if (accept && (3'(i) < burst.count)) begin
            fifo_ff[wr_ptr_ff + PTR_W'(i)] <= '{
               out_byte:    burst.data[i],
               run_last:    (3'(i + 1) == burst.count),
               string_last: (3'(i + 1) == burst.count) && req_chan.string_end
            };
         end
      end
   end

   assign rsp_chan.valid       = (count_ff != '0);
   assign rsp_chan.out_byte    = fifo_ff[rd_ptr_ff].out_byte;
   assign rsp_chan.run_last    = fifo_ff[rd_ptr_ff].run_last;
   assign rsp_chan.string_last = fifo_ff[rd_ptr_ff].string_last;

   `UTF8S_ASSERT_IMP(a_fifo_bound, clock, reset, 1'b1, count_ff <= CNT_W'(FIFO_DEPTH), "result queue overflow")
   `UTF8S_ASSERT_NXT(a_fifo_count, clock, reset, 1'b1, count_ff == $past(count_ff) + $past(push_cnt) - $past(pop_cnt), "result queue count slipped")
   `UTF8S_ASSERT_IMP(a_str_last_run_last, clock, reset, rsp_chan.valid && rsp_chan.string_last, rsp_chan.run_last, "string end not on a run end")

endmodule

[verif/utf8_byte_sanitizer_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the UTF-8 byte sanitizer: directed table, random strings.
module utf8_byte_sanitizer_tb;
   import utf8s_pkg::*;

   localparam int LIMIT_CYCLES = 200_000;
   localparam int HOLD_CYCLES  = 80;
   localparam int RANDOM_BYTES = 305;
   localparam int CALM_TAIL    = 60;
   localparam int DRAIN_CYCLES = 20;

   typedef struct packed {
      logic [7:0] b;
      logic       last;
   } text_byte_type;

   typedef struct packed {
      logic [7:0] b;
      logic       last;
      logic       known;
      entry_type  want;
   } dir_row_type;

   localparam entry_type NONE = '0;

   localparam dir_row_type DIR_ROWS [25] = '{
      '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1}},
      '{8'h7F, 1'b0, 1'b1, '{8'h7F, 1'b1, 1'b0}},
      '{8'h80, 1'b0, 1'b1, '{QMARK, 1'b1, 1'b0}},
      '{8'hBF, 1'b0, 1'b1, '{QMARK, 1'b1, 1'b0}},
      '{8'hF8, 1'b0, 1'b1, '{QMARK, 1'b1, 1'b0}},
      '{8'hFF, 1'b0, 1'b1, '{QMARK, 1'b1, 1'b0}},
      '{8'hC3, 1'b1, 1'b1, '{QMARK, 1'b1, 1'b1}},
      '{8'hC0, 1'b0, 1'b0, NONE},
      '{8'h80, 1'b0, 1'b0, NONE},
      '{8'hEF, 1'b0, 1'b0, NONE},
      '{8'hBF, 1'b0, 1'b0, NONE},
      '{8'hBF, 1'b0, 1'b0, NONE},
      '{8'hF7, 1'b0, 1'b0, NONE},
      '{8'hBF, 1'b0, 1'b0, NONE},
      '{8'hBF, 1'b0, 1'b0, NONE},
      '{8'hBF, 1'b1, 1'b0, NONE},
      '{8'hE2, 1'b0, 1'b0, NONE},
      '{8'h82, 1'b0, 1'b0, NONE},
      '{8'h41, 1'b0, 1'b0, NONE},
      '{8'hF4, 1'b0, 1'b0, NONE},
      '{8'h8F, 1'b0, 1'b0, NONE},
      '{8'hBF, 1'b1, 1'b0, NONE},
      '{8'hDF, 1'b0, 1'b0, NONE},
      '{8'hFF, 1'b0, 1'b0, NONE},
      '{8'hF0, 1'b1, 1'b0, NONE}
   };

   logic clock = 1'b0;
   logic reset;

   utf8s_req_if req_chan ();
   utf8s_rsp_if rsp_chan ();

   utf8_byte_sanitizer u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   // predictor state
   logic [7:0] held_bytes [3];
   logic [1:0] held_cnt;
   logic [2:0] run_len;
   entry_type  step_bytes [$];
   entry_type  clean_bytes_q [$];

   text_byte_type text_q [$];
   int            err_cnt = 0;
   int            cycle_cnt = 0;
   bit            calm = 1'b0;
   bit            hold_off_go = 1'b0;
   bit            hold_off_done = 1'b0;
   entry_type     got_e;
   entry_type     want_e;

   task automatic emit(input logic [7:0] b);
      entry_type e;
      e = '{b, 1'b0, 1'b0};
      step_bytes = {step_bytes, e};
   endtask

   task automatic flush_held();
      for (int k = 0; k < held_cnt; k++) emit(QMARK);
      held_cnt = '0;
      run_len  = '0;
   endtask

   task automatic take_fresh(input logic [7:0] b, input logic last);
      logic [2:0] len;
      casez (b)
         8'b0???????: len = 3'd1;
         8'b110?????: len = 3'd2;
         8'b1110????: len = 3'd3;
         8'b11110???: len = 3'd4;
         default:     len = 3'd0;
      endcase
      if (len == 3'd1) begin
         emit(b);
      end else if (len == 3'd0 || last) begin
         emit(QMARK);
      end else begin
         held_bytes[0] = b;
         held_cnt      = 2'd1;
         run_len       = len;
      end
   endtask

   task automatic sanitize_byte(input logic [7:0] b, input logic last);
      entry_type tail;
      step_bytes.delete();
      if (held_cnt == 0) begin
         take_fresh(b, last);
      end else if (b[7:6] == 2'b10) begin
         if (3'(held_cnt) + 3'd1 >= run_len) begin
            for (int k = 0; k < held_cnt; k++) emit(held_bytes[k]);
            emit(b);
            held_cnt = '0;
            run_len  = '0;
         end else begin
            held_bytes[held_cnt] = b;
            held_cnt = held_cnt + 2'd1;
            if (last) flush_held();
         end
      end else begin
         flush_held();
         take_fresh(b, last);
      end
      if (step_bytes.size() > 0) begin
         tail = step_bytes.pop_back();
         tail.run_last    = 1'b1;
         tail.string_last = last;
         step_bytes = {step_bytes, tail};
      end
   endtask

   task automatic report_mismatch(input string what, input entry_type got,
                                  input entry_type want);
      err_cnt++;
      $display("%0t: %s: got %h/%b/%b, want %h/%b/%b", $time, what,
               got.out_byte, got.run_last, got.string_last,
               want.out_byte, want.run_last, want.string_last);
   endtask

   // one transfer on the input channel; updates the predictor when taken
   task automatic drive_byte(input logic [7:0] b, input logic last);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.in_byte    <= b;
      req_chan.string_end <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sanitize_byte(b, last);
   endtask

   task automatic add_string();
      int            n_chars;
      int            kind;
      int            len;
      int            full;
      logic [7:0]    lead;
      text_byte_type tb;
      n_chars = $urandom_range(1, 8);
      for (int c = 0; c < n_chars; c++) begin
         kind = $urandom_range(0, 9);
         full = $urandom_range(2, 4);
         case (full)
            2:       lead = {3'b110, 5'($urandom)};
            3:       lead = {4'b1110, 4'($urandom)};
            default: lead = {5'b11110, 3'($urandom)};
         endcase
         if (kind <= 3) begin
            lead = 8'($urandom_range(0, 127));
            len  = 1;
         end else if (kind <= 7) begin
            len = full;
         end else if (kind == 8) begin
            len = $urandom_range(1, full - 1);
         end else begin
            lead = 8'($urandom);
            len  = 1;
         end
         tb = '{lead, 1'b0};
         text_q = {text_q, tb};
         for (int k = 1; k < len; k++) begin
            tb = '{8'h80 | 8'($urandom_range(0, 63)), 1'b0};
            text_q = {text_q, tb};
         end
      end
      tb = text_q.pop_back();
      tb.last = 1'b1;
      text_q = {text_q, tb};
   endtask

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > LIMIT_CYCLES) begin
         $display("utf8_byte_sanitizer regression: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got_e = '{rsp_chan.out_byte, rsp_chan.run_last, rsp_chan.string_last};
         if (clean_bytes_q.size() == 0) begin
            report_mismatch("unexpected transfer", got_e, NONE);
         end else begin
            want_e = clean_bytes_q.pop_front();
            if (got_e.out_byte !== want_e.out_byte)
               report_mismatch("out_byte", got_e, want_e);
            if (got_e.run_last !== want_e.run_last)
               report_mismatch("run_last", got_e, want_e);
            if (got_e.string_last !== want_e.string_last)
               report_mismatch("string_last", got_e, want_e);
         end
      end
   end

   initial begin : rsp_side
      rsp_chan.ready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         @(posedge clock);
         if (hold_off_go && !hold_off_done) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_done = 1'b1;
            rsp_chan.ready <= 1'b1;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin : req_side
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.in_byte    = 8'h00;
      req_chan.string_end = 1'b0;
      held_cnt            = '0;
      run_len             = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIR_ROWS[i]) begin
         drive_byte(DIR_ROWS[i].b, DIR_ROWS[i].last);
         if (DIR_ROWS[i].known)
            clean_bytes_q = {clean_bytes_q, DIR_ROWS[i].want};
         else
            foreach (step_bytes[k]) clean_bytes_q = {clean_bytes_q, step_bytes[k]};
      end

      while (text_q.size() < RANDOM_BYTES) add_string();
      foreach (text_q[i]) begin
         calm = (i >= text_q.size() - CALM_TAIL);
         if (i == 60) hold_off_go = 1'b1;
         if (i == 150) begin
            // sender waits for the result queue to run dry
            req_chan.valid <= 1'b0;
            do @(posedge clock); while (clean_bytes_q.size() != 0);
         end
         drive_byte(text_q[i].b, text_q[i].last);
         foreach (step_bytes[k]) clean_bytes_q = {clean_bytes_q, step_bytes[k]};
      end
      req_chan.valid <= 1'b0;

      while (clean_bytes_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_cnt == 0)
         $display("utf8_byte_sanitizer regression: pass");
      else
         $display("utf8_byte_sanitizer regression: fail");
      $finish;
   end
endmodule
